[rtl/hrlp_pkg.sv]
package hrlp_pkg;

   // item key and tag field masks
   localparam logic [7:0] KEY_MASK       = 8'hfc;
   localparam logic [7:0] LONG_MASK      = 8'hf0;
   localparam logic [1:0] SIZE_MASK      = 2'h3;

   // item keys that the parser acts on
   localparam logic [7:0] KEY_REPORT_CNT = 8'h94;
   localparam logic [7:0] KEY_INPUT      = 8'h80;
   localparam logic [7:0] KEY_OUTPUT     = 8'h90;

   // data size codes
   localparam logic [1:0] SIZE_ZERO      = 2'd0;
   localparam logic [1:0] SIZE_ONE       = 2'd1;
   localparam logic [1:0] SIZE_TWO       = 2'd2;
   localparam logic [1:0] SIZE_FOUR      = 2'd3;

   // parse phases
   localparam logic [1:0] PH_TAG         = 2'd0;
   localparam logic [1:0] PH_ONE         = 2'd1;
   localparam logic [1:0] PH_LOW         = 2'd2;
   localparam logic [1:0] PH_HIGH        = 2'd3;

   typedef struct packed {
      logic [1:0]  phase;
      logic [7:0]  item_key;
      logic [7:0]  low_data_byte;
      logic [15:0] report_count;
      logic [15:0] in_length;
      logic [15:0] out_length;
      logic        error_seen;
   } hrlp_state_type;

   typedef struct packed {
      logic [15:0] input_report_length;
      logic [15:0] output_report_length;
      logic        parse_error;
   } hrlp_result_type;

endpackage

[rtl/hrlp_req_if.sv]
interface hrlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] descriptor_byte;
   logic       last_byte;

   modport source (output valid, output descriptor_byte, output last_byte, input ready);
   modport sink   (input valid, input descriptor_byte, input last_byte, output ready);
endinterface

[rtl/hrlp_rsp_if.sv]
interface hrlp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] input_report_length;
   logic [15:0] output_report_length;
   logic        parse_error;

   modport source (output valid, output input_report_length, output output_report_length,
                   output parse_error, input ready);
   modport sink   (input valid, input input_report_length, input output_report_length,
                   input parse_error, output ready);
endinterface

[rtl/hrlp_step.sv]
module hrlp_step
   import hrlp_pkg::*;
(
   input  hrlp_state_type  state_cur,
   input  logic [7:0]      descriptor_byte,
   input  logic            last_byte,
   output hrlp_state_type  state_next,
   output hrlp_result_type result
);

   // effect of one completed short item on the report count and length registers
   function automatic hrlp_state_type apply_item(hrlp_state_type s, logic [7:0] key,
                                                 logic [15:0] val);
      hrlp_state_type r;
      r = s;
      if (key == KEY_REPORT_CNT) begin
         r.report_count = val;
      end else if (key == KEY_INPUT) begin
         r.in_length = s.report_count;
      end else if (key == KEY_OUTPUT) begin
         r.out_length = s.report_count;
      end
      return r;
   endfunction

   logic [7:0]     tag_key;
   logic [1:0]     tag_size;
   hrlp_state_type work;

   assign tag_key  = descriptor_byte & KEY_MASK;
   assign tag_size = descriptor_byte[1:0] & SIZE_MASK;

   // decode one byte against the current phase
   always_comb begin
      work = state_cur;
      if (!state_cur.error_seen) begin
         unique case (state_cur.phase)
            PH_TAG: begin
               if ((tag_key & LONG_MASK) == LONG_MASK || tag_size == SIZE_FOUR) begin
                  work.error_seen = 1'b1;
               end else if (tag_size == SIZE_ZERO) begin
                  work = apply_item(state_cur, tag_key, 16'd0);
               end else if (last_byte) begin
                  work.error_seen = 1'b1;
               end else begin
                  work.item_key = tag_key;
                  work.phase    = (tag_size == SIZE_ONE) ? PH_ONE : PH_LOW;
               end
            end
            PH_ONE: begin
               work = apply_item(state_cur, state_cur.item_key, {8'd0, descriptor_byte});
               work.phase         = PH_TAG;
               work.item_key      = 8'd0;
               work.low_data_byte = 8'd0;
            end
            PH_LOW: begin
               if (last_byte) begin
                  work.error_seen = 1'b1;
               end else begin
                  work.low_data_byte = descriptor_byte;
                  work.phase         = PH_HIGH;
               end
            end
            PH_HIGH: begin
               work = apply_item(state_cur, state_cur.item_key,
                                 {descriptor_byte, state_cur.low_data_byte});
               work.phase         = PH_TAG;
               work.item_key      = 8'd0;
               work.low_data_byte = 8'd0;
            end
            default: work = state_cur;
         endcase
      end
   end

   // report and clear on the final byte
   assign result.input_report_length  = work.in_length;
   assign result.output_report_length = work.out_length;
   assign result.parse_error          = work.error_seen;
   assign state_next = last_byte ? hrlp_state_type'('0) : work;

endmodule

[rtl/hid_report_length_parser_unit.sv]
// HID report descriptor length parser. Feed the descriptor one byte per transaction on
// req_if with last_byte set on its final byte; one transaction per descriptor comes out on
// rsp_if carrying the report count in force at the last Input and Output main items and a
// sticky error flag for long items, 4-byte data or an item cut off by the final byte. A byte
// is held in the input register and its result, if any, is then registered in the result
// register, so the unit sustains one byte per clock; a final byte waits in the input register
// only while the previous result has not yet been taken on rsp_if. The parser state is
// decoded combinationally and clears itself after every final byte.
module hid_report_length_parser_unit
   import hrlp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   hrlp_req_if.sink       req_if,
   hrlp_rsp_if.source     rsp_if
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            in_last_ff, in_last_in;
   hrlp_state_type  state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   hrlp_result_type rsp_data_ff, rsp_data_in;

   hrlp_state_type  step_state;
   hrlp_result_type step_result;
   logic            advance;

   // the held byte moves on unless its result has nowhere to go
   assign advance      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   hrlp_step u_step (
      .state_cur       (state_ff),
      .descriptor_byte (in_byte_ff),
      .last_byte       (in_last_ff),
      .state_next      (step_state),
      .result          (step_result)
   );

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
         in_byte_in  = req_if.descriptor_byte;
         in_last_in  = req_if.last_byte;
      end
   end

   // parser state and result register
   always_comb begin
      state_in     = advance ? step_state : state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid                = rsp_valid_ff;
   assign rsp_if.input_report_length  = rsp_data_ff.input_report_length;
   assign rsp_if.output_report_length = rsp_data_ff.output_report_length;
   assign rsp_if.parse_error          = rsp_data_ff.parse_error;

   // an error only ever stands while waiting for a tag byte
   a_error_in_tag_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.error_seen |-> state_ff.phase == PH_TAG)
      else $error("error flag set outside tag phase");

   // the final byte leaves the parser fully cleared
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff == hrlp_state_type'('0))
      else $error("parser state not cleared after final byte");

   // a new result appears only after a final byte was decoded
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("result without a final byte");

   // a pending result is never overwritten by another final byte
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |-> !(advance && in_last_ff))
      else $error("pending result overwritten");

endmodule

[tb/hrlp_length_checker.sv]
module hrlp_length_checker
   import hrlp_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   hrlp_req_if   req_if,
   hrlp_rsp_if   rsp_if,
   output int    fail_count,
   output int    outstanding,
   output int    result_count,
   output int    malformed_count
);

   // predicted parser state
   logic [1:0]  parse_phase;
   logic [7:0]  cur_key;
   logic [7:0]  low_byte;
   logic [15:0] count_value;
   logic [15:0] input_len;
   logic [15:0] output_len;
   logic        malformed;

   // one expected length report per descriptor still in flight
   hrlp_result_type length_q[$];

   task automatic clear_descriptor();
      parse_phase = PH_TAG;
      cur_key     = '0;
      low_byte    = '0;
      count_value = '0;
      input_len   = '0;
      output_len  = '0;
      malformed   = 1'b0;
   endtask

   // act on one complete short item
   task automatic take_item(input logic [7:0] key, input logic [15:0] value);
      if (key == KEY_REPORT_CNT) begin
         count_value = value;
      end else if (key == KEY_INPUT) begin
         input_len = count_value;
      end else if (key == KEY_OUTPUT) begin
         output_len = count_value;
      end
   endtask

   // advance the parser by one descriptor byte, queue a report on the final byte
   task automatic predict_lengths(input logic [7:0] b, input logic last);
      logic [7:0] key;
      logic [1:0] size;
      hrlp_result_type want;
      if (!malformed) begin
         case (parse_phase)
            PH_TAG: begin
               key  = b & KEY_MASK;
               size = b[1:0] & SIZE_MASK;
               if ((key & LONG_MASK) == LONG_MASK || size == SIZE_FOUR) begin
                  malformed = 1'b1;
               end else if (size == SIZE_ZERO) begin
                  take_item(key, 16'h0000);
               end else if (last) begin
                  // tag with data cut off by the end of the descriptor
                  malformed = 1'b1;
               end else begin
                  cur_key     = key;
                  parse_phase = (size == SIZE_ONE) ? PH_ONE : PH_LOW;
               end
            end
            PH_ONE: begin
               take_item(cur_key, {8'h00, b});
               parse_phase = PH_TAG;
            end
            PH_LOW: begin
               if (last) begin
                  malformed = 1'b1;
               end else begin
                  low_byte    = b;
                  parse_phase = PH_HIGH;
               end
            end
            default: begin
               take_item(cur_key, {b, low_byte});
               parse_phase = PH_TAG;
            end
         endcase
      end
      if (last) begin
         want.input_report_length  = input_len;
         want.output_report_length = output_len;
         want.parse_error          = malformed;
         length_q.push_back(want);
         clear_descriptor();
      end
   endtask

   task automatic report_fault(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   initial begin
      clear_descriptor();
   end

   // compare results first, then predict from the byte taken at the same edge
   always @(posedge clock) begin
      hrlp_result_type want;
      if (reset) begin
         clear_descriptor();
         length_q.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (length_q.size() == 0) begin
               report_fault($sformatf("result with nothing pending (in %0h out %0h err %0b)",
                                      rsp_if.input_report_length,
                                      rsp_if.output_report_length, rsp_if.parse_error));
            end else begin
               want = length_q.pop_front();
               if (rsp_if.input_report_length !== want.input_report_length)
                  report_fault($sformatf("input_report_length got %0h expected %0h",
                                         rsp_if.input_report_length,
                                         want.input_report_length));
               if (rsp_if.output_report_length !== want.output_report_length)
                  report_fault($sformatf("output_report_length got %0h expected %0h",
                                         rsp_if.output_report_length,
                                         want.output_report_length));
               if (rsp_if.parse_error !== want.parse_error)
                  report_fault($sformatf("parse_error got %0b expected %0b",
                                         rsp_if.parse_error, want.parse_error));
               result_count++;
               if (want.parse_error)
                  malformed_count++;
            end
         end
         if (req_if.valid && req_if.ready)
            predict_lengths(req_if.descriptor_byte, req_if.last_byte);
      end
      outstanding = length_q.size();
   end

endmodule

[tb/tb_hid_report_length_parser_unit.sv]
module tb_hid_report_length_parser_unit;
   import hrlp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrlp_req_if req_if();
   hrlp_rsp_if rsp_if();

   int fail_count;
   int outstanding;
   int result_count;
   int malformed_count;

   int bytes_sent;
   int descriptors_sent;
   bit no_idle;

   logic [7:0] desc_q[$];

   // directed descriptors, bit 8 marks the final byte
   localparam logic [8:0] DIRECTED_BYTES[24] = '{
      // max two-byte count into input, zero-size count, output picks up zero
      9'h096, 9'h0ff, 9'h0ff, 9'h080, 9'h094, 9'h190,
      // one-byte item whose data byte is the final byte
      9'h095, 9'h000, 9'h091, 9'h17f,
      // long item as the final byte after a valid input item
      9'h095, 9'h005, 9'h081, 9'h000, 9'h1fe,
      // four-byte size code, then an input item that must be ignored
      9'h095, 9'h003, 9'h083, 9'h180,
      // tag with data arriving as the final byte
      9'h095, 9'h002, 9'h181,
      // two-byte item cut after its low byte
      9'h096, 9'h134
   };

   hid_report_length_parser_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   hrlp_length_checker length_check (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .result_count    (result_count),
      .malformed_count (malformed_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hand one byte over, with a random gap first
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.descriptor_byte <= b;
      req_if.last_byte       <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_descriptor();
      foreach (desc_q[i])
         send_byte(desc_q[i], i == desc_q.size() - 1);
      descriptors_sent++;
   endtask

   // tag byte followed by its little-endian data
   task automatic push_item(input logic [7:0] key, input logic [1:0] size,
                            input logic [15:0] value);
      desc_q.push_back(key | {6'b000000, size});
      if (size != SIZE_ZERO)
         desc_q.push_back(value[7:0]);
      if (size == SIZE_TWO)
         desc_q.push_back(value[15:8]);
   endtask

   function automatic logic [7:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return KEY_REPORT_CNT;
      if (r < 5) return KEY_INPUT;
      if (r < 7) return KEY_OUTPUT;
      return {4'($urandom_range(0, 14)), 2'($urandom_range(0, 3)), 2'b00};
   endfunction

   // mostly well-formed descriptors, some broken at the end, some pure noise
   task automatic build_random_descriptor();
      int kind;
      int n_items;
      int tail;
      desc_q.delete();
      kind    = $urandom_range(0, 99);
      n_items = $urandom_range(1, 8);
      for (int i = 0; i < n_items; i++)
         push_item(pick_key(), 2'($urandom_range(0, 2)), 16'($urandom));
      if (kind >= 88) begin
         desc_q.delete();
         repeat ($urandom_range(1, 6)) desc_q.push_back(8'($urandom));
      end else if (kind >= 70) begin
         tail = $urandom_range(0, 3);
         case ($urandom_range(0, 3))
            0: desc_q.push_back({4'hf, 4'($urandom)});
            1: desc_q.push_back({pick_key() & KEY_MASK} | {6'b000000, SIZE_FOUR});
            2: begin
               desc_q.push_back(pick_key() | {6'b000000, 2'($urandom_range(1, 2))});
               tail = 0;
            end
            default: begin
               desc_q.push_back(pick_key() | {6'b000000, SIZE_TWO});
               desc_q.push_back(8'($urandom));
               tail = 0;
            end
         endcase
         repeat (tail) desc_q.push_back(8'($urandom));
      end
   endtask

   // result side: random stall before each result
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      req_if.valid           <= 1'b0;
      req_if.descriptor_byte <= 8'h00;
      req_if.last_byte       <= 1'b0;
      no_idle = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_BYTES[i])
         send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
      descriptors_sent += 6;

      while (bytes_sent < 24 + 1550) begin
         build_random_descriptor();
         no_idle = ($urandom_range(0, 4) == 0);
         send_descriptor();
      end
      no_idle = 1'b0;
      req_if.valid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("sent %0d descriptor bytes in %0d descriptors", bytes_sent, descriptors_sent);
      $display("checked %0d length reports, %0d of them flagged malformed",
               result_count, malformed_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
